### hw/rtl/piece_sha1_hasher_defines.svh
// Assertion macros for the piece SHA-1 hasher.
`ifndef PIECE_SHA1_HASHER_DEFINES_SVH
`define PIECE_SHA1_HASHER_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define PSH_ASSERT_IMP(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication checked outside reset.
`define PSH_ASSERT_NEXT(lbl, clk, rst, a, c, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

### hw/rtl/psh_pkg.sv
// Package with types, constants and round functions of the piece SHA-1 hasher.
`default_nettype none
package psh_pkg;
   localparam int PIECE_INDEX_BITS_DEFAULT = 26;
   localparam int SIZE_BITS = 28;
   localparam logic [SIZE_BITS-1:0] PIECE_SIZE_RESET = 28'd262144;
   localparam logic [159:0] SHA_IV =
      160'h67452301_EFCDAB89_98BADCFE_10325476_C3D2E1F0;

   typedef enum logic [2:0] {
      ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
   } state_type;

   typedef struct packed {
      logic start;
   } comp_ctrl_type;

   function automatic logic [31:0] rotl5(input logic [31:0] x);
      rotl5 = {x[26:0], x[31:27]};
   endfunction

   function automatic logic [31:0] round_f(input logic [6:0] r,
                                           input logic [31:0] b,
                                           input logic [31:0] c,
                                           input logic [31:0] d);
      if (r < 7'd20) round_f = (b & c) | (~b & d);
      else if (r < 7'd40) round_f = b ^ c ^ d;
      else if (r < 7'd60) round_f = (b & c) | (b & d) | (c & d);
      else round_f = b ^ c ^ d;
   endfunction

   function automatic logic [31:0] round_k(input logic [6:0] r);
      if (r < 7'd20) round_k = 32'h5A827999;
      else if (r < 7'd40) round_k = 32'h6ED9EBA1;
      else if (r < 7'd60) round_k = 32'h8F1BBCDC;
      else round_k = 32'hCA62C1D6;
   endfunction
endpackage
`default_nettype wire

### hw/rtl/psh_core.sv
// Iterative SHA-1 compression unit, one round per cycle over a 16-word schedule.
`default_nettype none
module psh_core (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire psh_pkg::comp_ctrl_type ctrl,
   input  wire logic [511:0]        block,
   input  wire logic [159:0]        chain_in,
   output logic [159:0]             chain_out,
   output logic                     done
);
   import psh_pkg::*;
   logic [31:0] w_ff [16];
   logic [31:0] a_ff, b_ff, c_ff, d_ff, e_ff;
   logic [6:0]  round_ff;
   logic        run_ff;
   logic [31:0] wnew, wcur, t;
   logic [159:0] out_ff;
   logic        done_ff;

   assign wcur = w_ff[0];
   always_comb begin
      wnew = w_ff[13] ^ w_ff[8] ^ w_ff[2] ^ w_ff[0];
      wnew = {wnew[30:0], wnew[31]};
      t = rotl5(a_ff) + round_f(round_ff, b_ff, c_ff, d_ff) + e_ff
          + round_k(round_ff) + wcur;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff <= 1'b0;
         done_ff <= 1'b0;
         round_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctrl.start) begin
            run_ff <= 1'b1;
            round_ff <= '0;
         end else if (run_ff) begin
            if (round_ff == 7'd79) begin
               run_ff <= 1'b0;
               done_ff <= 1'b1;
            end
            round_ff <= round_ff + 7'd1;
         end
      end
      if (ctrl.start) begin
         for (int i = 0; i < 16; i++) w_ff[i] <= block[511-32*i -: 32];
         {a_ff, b_ff, c_ff, d_ff, e_ff} <= chain_in;
      end else if (run_ff) begin
         for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
         w_ff[15] <= wnew;
         e_ff <= d_ff; d_ff <= c_ff; c_ff <= {b_ff[1:0], b_ff[31:2]};
         b_ff <= a_ff; a_ff <= t;
         if (round_ff == 7'd79)
            out_ff <= {chain_in[159:128] + t, chain_in[127:96] + a_ff,
                       chain_in[95:64] + {b_ff[1:0], b_ff[31:2]},
                       chain_in[63:32] + c_ff, chain_in[31:0] + d_ff};
      end
   end
   assign chain_out = out_ff;
   assign done = done_ff;
endmodule
`default_nettype wire

### hw/rtl/piece_sha1_hasher.sv
// Top level of the piece SHA-1 hasher: byte intake, padding sequencer and digest output.
// A byte that completes a 64-byte block holds off further bytes while the round unit
// runs its 80 rounds; other bytes leave the input ready for the next byte.
// A piece end pads the last block and may add one more padding block, then five output words.
// The single round unit bounds the input rate: bytes are held off while a block is compressed.
// Reset is synchronous and active high; it restores the initial hash and counters.
`default_nettype none
module piece_sha1_hasher #(
   parameter int PIECE_INDEX_BITS = psh_pkg::PIECE_INDEX_BITS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_we,
   input  wire logic [27:0] csr_wdata,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // data_byte
   input  wire logic        req_tlast,   // end_of_stream
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [63:0]      rsp_tdata,   // digest_word, word_index, piece_index, pad
   output logic             rsp_tlast    // last_word
);
   import psh_pkg::*;
   state_type state_ff, state_in;
   logic [SIZE_BITS-1:0] size_ff, fill_ff;
   logic [511:0] blk_ff;
   logic [5:0]   bfill_ff;
   logic [159:0] chain_ff, chain_out;
   logic [PIECE_INDEX_BITS-1:0] count_ff, pidx_ff;
   logic [SIZE_BITS:0] len_ff;
   logic [2:0] widx_ff;
   logic mark_ff, fin_ff, padlen_ff, core_done;
   logic [159:0] dig_ff;
   comp_ctrl_type cc;
   logic [SIZE_BITS:0] limit, nfill;
   logic acc;

   assign limit = (size_ff == '0) ? {1'b1, {SIZE_BITS{1'b0}}} : {1'b0, size_ff};
   assign nfill = {1'b0, fill_ff} + 1'b1;
   assign acc = req_tvalid && req_tready;

   psh_core u_core (.clock, .reset, .ctrl(cc), .block(blk_ff), .chain_in(chain_ff),
                    .chain_out, .done(core_done));

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (acc && (bfill_ff == 6'd63 || nfill >= limit || req_tlast))
            state_in = ST_LOAD;
         ST_LOAD: state_in = (bfill_ff == 6'd0 && !fin_ff) ? ST_ROUND :
                             (bfill_ff == 6'd0 && padlen_ff) ? ST_ROUND :
                             (bfill_ff == 6'd0) ? ST_ROUND : ST_PAD;
         ST_ROUND: if (core_done) state_in = ST_ADD;
         ST_ADD: state_in = !fin_ff ? ST_IDLE : (padlen_ff ? ST_EMIT : ST_PAD);
         ST_PAD: state_in = ST_LOAD;
         ST_EMIT: if (rsp_tready && widx_ff == 3'd4) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      cc.start = (state_ff == ST_LOAD) && (bfill_ff == 6'd0);
      rsp_tvalid = (state_ff == ST_EMIT);
      rsp_tlast = (widx_ff == 3'd4);
      rsp_tdata = '0;
      rsp_tdata[31:0] = dig_ff[159 - 32*widx_ff -: 32];
      rsp_tdata[34:32] = widx_ff;
      rsp_tdata[35 +: 26] = 26'(pidx_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         size_ff <= PIECE_SIZE_RESET;
         fill_ff <= '0; bfill_ff <= '0; count_ff <= '0;
         chain_ff <= SHA_IV; fin_ff <= 1'b0; padlen_ff <= 1'b0; widx_ff <= '0;
         mark_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) size_ff <= csr_wdata;
         case (state_ff)
            ST_IDLE: if (acc) begin
               blk_ff[511 - 8*bfill_ff -: 8] <= req_tdata;
               bfill_ff <= bfill_ff + 6'd1;
               if (nfill >= limit || req_tlast) begin
                  fin_ff <= 1'b1; padlen_ff <= 1'b0;
                  len_ff <= nfill; fill_ff <= '0;
                  pidx_ff <= count_ff;
                  count_ff <= req_tlast ? '0 : count_ff + 1'b1;
               end else fill_ff <= nfill[SIZE_BITS-1:0];
            end
            ST_LOAD: if (bfill_ff != 6'd0 && fin_ff && !padlen_ff) begin
               blk_ff[511 - 8*bfill_ff -: 8] <= 8'h80;
               mark_ff <= 1'b1;
            end
            ST_PAD: begin
               // Zero the rest of the block after the marker; add the length if it fits.
               for (int i = 0; i < 64; i++)
                  if (i[5:0] > bfill_ff && (i < 56 || bfill_ff >= 6'd56))
                     blk_ff[511-8*i -: 8] <= 8'h00;
               if (bfill_ff < 6'd56) begin
                  blk_ff[63:0] <= {32'd0, len_ff, 3'b000};
                  padlen_ff <= 1'b1;
               end
               bfill_ff <= 6'd0;
            end
            ST_ADD: begin
               if (fin_ff && padlen_ff) begin
                  dig_ff <= chain_out; chain_ff <= SHA_IV; widx_ff <= '0;
                  mark_ff <= 1'b0;
               end else begin
                  chain_ff <= chain_out;
                  if (fin_ff) begin
                     // A second block of zeros and length, led by the marker when the
                     // piece ended exactly on a block boundary.
                     bfill_ff <= 6'd0;
                     blk_ff <= mark_ff ? '0 : {8'h80, 504'd0};
                  end
               end
            end
            ST_EMIT: if (rsp_tready) begin
               widx_ff <= widx_ff + 3'd1;
               if (widx_ff == 3'd4) begin fin_ff <= 1'b0; padlen_ff <= 1'b0; end
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

### hw/rtl/psh_checker.sv
// Port checker for the piece SHA-1 hasher and its bind statement.
`default_nettype none
`include "piece_sha1_hasher_defines.svh"
module psh_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [63:0] rsp_tdata,
   input wire logic        rsp_tlast
);
   `PSH_ASSERT_IMP(a_no_overlap, clock, reset, rsp_tvalid, !req_tready, "input taken during output")
   `PSH_ASSERT_IMP(a_last_idx, clock, reset, rsp_tvalid, rsp_tlast == (rsp_tdata[34:32] == 3'd4), "last flag mismatch")
   `PSH_ASSERT_NEXT(a_idx_step, clock, reset, rsp_tvalid && rsp_tready && !rsp_tlast, rsp_tvalid && rsp_tdata[34:32] == $past(rsp_tdata[34:32]) + 3'd1, "word order broken")
endmodule
bind piece_sha1_hasher psh_checker u_psh_checker (.*);
`default_nettype wire
